>>> sv/lcgr_pkg.sv
// Package for the LCG random range generator.
// Holds generator constants, item structs and the job record shared by all modules.
// No dependencies.
package lcgr_pkg;

    // Generator constants
    localparam logic [31:0] LCG_MUL  = 32'd73129;
    localparam logic [31:0] LCG_ADD  = 32'd95121;
    localparam logic [31:0] LCG_MOD  = 32'hFFFF_FFFF;
    localparam logic [31:0] SEED_DEF = 32'd1;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request item
    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_req;

    // Result item
    typedef struct packed {
        logic [31:0]        raw_word;
        logic signed [31:0] ranged_value;
        logic               span_zero_flag;
    } t_rsp;

    // Classified job passed from front to back
    typedef struct packed {
        logic [31:0] raw;
        logic [31:0] low;
        logic [31:0] span;
        logic        span_zero;
    } t_job;

endpackage

>>> sv/lcgr_front.sv
// Front end: holds the generator word, advances it per accepted item and
// classifies the range into a job record. Depends on lcgr_pkg.
module lcgr_front
    import lcgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_take,
    input  t_req        i_req,
    output t_job        o_job
);

    logic [31:0] r_gen;
    logic [31:0] n_gen;
    logic [31:0] w_t;
    logic [31:0] w_raw;

    // Next generator word: multiply-add mod 2^32, then fold 2^32-1 to zero
    assign w_t   = r_gen * LCG_MUL + LCG_ADD;
    assign w_raw = (w_t == LCG_MOD) ? 32'd0 : w_t;

    // Job record for the back end
    always_comb begin
        o_job.raw       = w_raw;
        o_job.low       = 32'(i_req.range_low);
        o_job.span      = 32'(i_req.range_high) - 32'(i_req.range_low) + 32'd1;
        o_job.span_zero = (o_job.span == 32'd0);
    end

    // Generator update: seed write reloads, an accepted item advances
    always_comb begin
        n_gen = r_gen;
        if (i_cfg_we) begin
            n_gen = (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
        end else if (i_take) begin
            n_gen = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= SEED_DEF;
        end else begin
            r_gen <= n_gen;
        end
    end

endmodule

>>> sv/lcgr_queue.sv
// Short job queue between front and back end.
// Register-based FIFO of t_job records. Depends on lcgr_pkg.
module lcgr_queue
    import lcgr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wdata,
    input  logic i_rd,
    output t_job o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/lcgr_back.sv
// Back end: radix-2 restoring divider that reduces the raw word by the span,
// adds the low bound and holds the result in an output register. Depends on lcgr_pkg.
module lcgr_back
    import lcgr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_job i_job,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_bstate;

    t_bstate     r_state;
    t_bstate     n_state;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_span;
    logic [31:0] r_low;
    logic [31:0] r_raw;
    logic        r_zero;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    t_rsp        r_out;
    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_load;

    assign o_empty = !r_out_valid;
    assign o_rsp   = r_out;
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_pop);

    // One quotient bit per cycle: shift in the next dividend bit, trial subtract
    assign w_sh   = {r_rem, r_dvd[31]};
    assign w_diff = w_sh - {1'b0, r_span};

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job.span_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_raw  <= i_job.raw;
            r_low  <= i_job.low;
            r_span <= i_job.span;
            r_zero <= i_job.span_zero;
            r_dvd  <= i_job.raw;
            r_cnt  <= 5'd0;
            // span of zero: ranged is low + raw, no division
            r_rem  <= i_job.span_zero ? i_job.raw : 32'd0;
        end else if (r_state == S_DIV) begin
            r_rem <= w_diff[32] ? w_sh[31:0] : w_diff[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.raw_word       <= r_raw;
            r_out.ranged_value   <= signed'(r_low + r_rem);
            r_out.span_zero_flag <= r_zero;
        end
    end

endmodule

>>> sv/lcg_random_range_generator_top.sv
// Top level of the LCG random range generator.
// Instantiates lcgr_front, lcgr_queue and lcgr_back; depends on lcgr_pkg.
//
// Each accepted request advances a 32-bit linear congruential generator
// (word*73129 + 95121 mod 2^32, then mod 2^32-1) and returns the new word plus
// low + word mod (high-low+1), in 32-bit wrap arithmetic; when that span wraps
// to zero the result is low + word and span_zero_flag is set. The generator
// advances at acceptance, so results keep request order. Writing the seed
// reloads the generator at once (zero loads one); write it only while idle.
// In the back end a request passes through pickup, 32 divider steps and result
// load, or pickup and result load when the span is zero; the radix-2 divider sets the
// sustained rate. A queue of QUEUE_DEPTH jobs lets requests be taken while the
// divider is busy, and a finished result waits in its own register.
module lcg_random_range_generator_top
    import lcgr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  t_req        i_req,
    output logic        empty,
    input  logic        pop,
    output t_rsp        o_rsp
);

    t_job w_job_in;
    t_job w_job_out;
    logic w_take;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;

    assign full   = w_q_full;
    assign w_take = push && !w_q_full;

    lcgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_req       (i_req),
        .o_job       (w_job_in)
    );

    lcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_take),
        .i_wdata (w_job_in),
        .i_rd    (w_q_pop),
        .o_rdata (w_job_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    lcgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_job     (w_job_out),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rsp     (o_rsp)
    );

    // Back end never takes a job from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("job taken from empty queue");

    // An item pushed into an empty queue is visible next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_q_empty) |=> !w_q_empty)
        else $error("pushed item lost");

    // The generator word never equals the modulus
    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rsp.raw_word != LCG_MOD))
        else $error("raw word out of range");

endmodule

>>> bench/tb_lcg_random_range_generator_top.sv
// Self-checking testbench for lcg_random_range_generator_top.
// Queue-driven request driver, result monitor with its own draw predictor.
// Depends on lcgr_pkg and the RTL of the generator.
`timescale 1ns / 100ps

module tb_lcg_random_range_generator_top;
    import lcgr_pkg::*;

    // Generator arithmetic, kept separate from the RTL copy
    localparam logic [31:0] GEN_MULT = 32'd73129;
    localparam logic [31:0] GEN_INC  = 32'd95121;
    localparam logic [31:0] GEN_TOP  = 32'hFFFF_FFFF;

    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving
    localparam int PHASE_ITEMS    = 175;
    localparam int NUM_SEEDS      = 5;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [31:0] cfg_wdata   = '0;
    logic        push        = 1'b0;
    logic        full;
    t_req        req         = '0;
    logic        empty;
    logic        pop         = 1'b0;
    t_rsp        rsp;

    // Pending requests and expected draws
    t_req        request_q[$];
    t_rsp        expected_draws[$];
    logic [31:0] gen_word = 32'd1;

    int          err_count   = 0;
    int          n_items     = 0;
    int          n_results   = 0;
    int          n_span_zero = 0;
    int          n_reversed  = 0;
    int          idle_cycles = 0;

    // Sender burst shaping
    int          burst_left  = 4;
    int          gap_left    = 0;

    // Receiver stall pattern
    logic [7:0]  rx_cycle    = '0;
    int          rx_mode     = 0;

    lcg_random_range_generator_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .push       (push),
        .full       (full),
        .i_req      (req),
        .empty      (empty),
        .pop        (pop),
        .o_rsp      (rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Next generator word and the range reduction of one request
    function automatic t_rsp predict_draw(input t_req r, input logic [31:0] word);
        t_rsp        p;
        logic [31:0] t;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        t    = word * GEN_MULT + GEN_INC;
        lo   = r.range_low;
        hi   = r.range_high;
        span = hi - lo + 32'd1;
        p.raw_word = (t == GEN_TOP) ? 32'd0 : t;
        if (span == 32'd0) begin
            p.ranged_value   = lo + p.raw_word;
            p.span_zero_flag = 1'b1;
        end else begin
            p.ranged_value   = lo + (p.raw_word % span);
            p.span_zero_flag = 1'b0;
        end
        return p;
    endfunction

    function automatic t_req random_request();
        t_req                  r;
        logic signed [31:0]    corners[5];
        corners = '{S_MIN, S_MAX, 32'sd0, -32'sd1, 32'sd1};
        r.range_low  = $urandom;
        r.range_high = $urandom;
        case ($urandom_range(0, 9)) inside
            [0:2]:   ;                                              // fully random
            [3:4]:   r.range_high = r.range_low + $urandom_range(0, 100);
            5:       r.range_high = r.range_low + ($urandom >> $urandom_range(0, 31));
            6:       r.range_high = r.range_low - 32'sd1;           // span wraps to zero
            7:       r.range_high = r.range_low - $urandom_range(2, 1000);  // reversed
            default: begin
                r.range_low  = corners[$urandom_range(0, 4)];
                r.range_high = corners[$urandom_range(0, 4)];
            end
        endcase
        return r;
    endfunction

    task automatic add_req(input logic signed [31:0] lo, input logic signed [31:0] hi);
        t_req r;
        r.range_low  = lo;
        r.range_high = hi;
        request_q.push_back(r);
    endtask

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Seed write; only called while nothing is in flight
    task automatic load_seed(input logic [31:0] seed);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        gen_word  = (seed == 32'd0) ? 32'd1 : seed;
    endtask

    // Wait for every request to go in and every draw to come out;
    // checked mid-cycle so the driver's updates at the edge have settled
    task automatic drain_results();
        while (request_q.size() != 0 || push || expected_draws.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                t_rsp p;
                p = predict_draw(req, gen_word);
                gen_word = p.raw_word;
                expected_draws.push_back(p);
                n_items++;
                if (!p.span_zero_flag && (req.range_high < req.range_low))
                    n_reversed++;
            end
            if (push && full) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (request_q.size() != 0) begin
                req  <= request_q.pop_front();
                push <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (expected_draws.size() == 0) begin
                    report_error($sformatf("unexpected result raw=%h ranged=%h flag=%b",
                                           rsp.raw_word, rsp.ranged_value, rsp.span_zero_flag));
                end else begin
                    t_rsp e;
                    e = expected_draws.pop_front();
                    if (e.span_zero_flag) n_span_zero++;
                    if (rsp.raw_word !== e.raw_word || rsp.ranged_value !== e.ranged_value
                        || rsp.span_zero_flag !== e.span_zero_flag)
                        report_error($sformatf(
                            "result %0d: exp raw=%h ranged=%h flag=%b, got raw=%h ranged=%h flag=%b",
                            n_results, e.raw_word, e.ranged_value, e.span_zero_flag,
                            rsp.raw_word, rsp.ranged_value, rsp.span_zero_flag));
                end
            end
            // pick a new stall pattern each time the 8-bit cycle counter wraps
            rx_cycle <= rx_cycle + 8'd1;
            if (rx_cycle == 8'd0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= (rx_cycle[3:0] < 4'd3);
                default: pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Watchdog on cycles where no item moves in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d draws outstanding",
                     idle_cycles, expected_draws.size());
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] inv;
        logic [31:0] seeds[NUM_SEEDS];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seed whose next step lands on the excluded top value, giving word zero
        inv = GEN_MULT;
        repeat (5) inv = inv * (32'd2 - GEN_MULT * inv);
        seeds = '{32'd0, 32'hFFFF_FFFF, (GEN_TOP - GEN_INC) * inv, 32'h8000_0000, $urandom};

        // Directed corners with the reset seed
        add_req(32'sd0, 32'sd0);
        add_req(S_MIN, S_MAX);          // full range, span zero
        add_req(S_MAX, S_MIN);          // reversed, span two
        add_req(32'sd0, -32'sd1);       // span zero
        add_req(32'sd5, 32'sd4);        // span zero
        add_req(32'sd1, 32'sd0);        // span zero
        add_req(S_MAX, S_MAX);
        add_req(S_MIN, S_MIN);
        add_req(-32'sd10, 32'sd10);
        add_req(32'sd10, -32'sd10);     // reversed
        add_req(32'sd0, S_MAX);         // span 2^31
        add_req(S_MIN, S_MAX - 32'sd1); // largest nonzero span
        add_req(-32'sd1, S_MAX);
        add_req(32'sd0, 32'sd1);
        add_req(32'sd0, 32'sd2);
        add_req(-32'sd1, -32'sd1);
        add_req(32'sd1, S_MIN);         // reversed, span 2^31
        add_req(S_MAX, 32'sd0);         // reversed
        add_req(32'sd100, 32'sd1123);
        add_req(-32'sd1, 32'sd0);
        repeat (PHASE_ITEMS - 20) request_q.push_back(random_request());
        drain_results();

        // Random phases, each after a seed write while idle
        foreach (seeds[i]) begin
            load_seed(seeds[i]);
            repeat (PHASE_ITEMS) request_q.push_back(random_request());
            drain_results();
        end

        $display("%0d requests and %0d results checked over %0d seeds,", n_items,
                 n_results, NUM_SEEDS + 1);
        $display("%0d with a zero span, %0d reversed ranges, %0d errors", n_span_zero,
                 n_reversed, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
